// ----- rtl/wrapped_voronoi_stone_shader_defines.svh -----
// Assertion macros shared by the shader RTL.
// Defining ASSERT_OFF removes every check; no other dependencies.
`ifndef WRAPPED_VORONOI_STONE_SHADER_DEFINES_SVH
`define WRAPPED_VORONOI_STONE_SHADER_DEFINES_SVH
`ifndef ASSERT_OFF
`define WVS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("check failed in the stone shader");
`define WVS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequence check failed in the stone shader");
`else
`define WVS_ASSERT(lbl, clk, rst_n, prop)
`define WVS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/wvs_pkg.sv -----
// Types, constants and small arithmetic functions of the stone shader.
// No dependencies; used by the channel interface users, the divider and the top level.
package wvs_pkg;

    localparam int COORD_W    = 8;
    localparam int COLOR_W    = 8;
    localparam int RAD_W      = 12;
    localparam int IDX_W      = 6;
    localparam int TILE_W     = 9;
    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int D2_W       = 17;
    localparam int R2_W       = 24;
    localparam int NUM_W      = 35;
    localparam int DEN_W      = 27;
    localparam int W_W        = 8;
    localparam int STEP_W     = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_RED    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_GREEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_BLUE   = 3'd4;

    localparam logic KIND_SEED  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [TILE_W-1:0] TILE_RESET = 9'd16;
    localparam logic [W_W-1:0]    MAX_WEIGHT = 8'd204;

    typedef struct packed {
        logic               kind;
        logic [IDX_W-1:0]   seed_index;
        logic [COORD_W-1:0] seed_x;
        logic [COORD_W-1:0] seed_y;
        logic [COLOR_W-1:0] seed_red;
        logic [COLOR_W-1:0] seed_green;
        logic [COLOR_W-1:0] seed_blue;
        logic [RAD_W-1:0]   seed_radius;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
    } t_in_item;

    typedef struct packed {
        logic [COLOR_W-1:0] out_red;
        logic [COLOR_W-1:0] out_green;
        logic [COLOR_W-1:0] out_blue;
        logic               inside_stone;
        logic [IDX_W-1:0]   winner_index;
        logic               out_of_range;
    } t_out_item;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [RAD_W-1:0]   radius;
    } t_seed;

    localparam int SEED_W = $bits(t_seed);

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic [W_W-1:0] quot;
    } t_div_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_SQUARE,
        S_TEST,
        S_DIV,
        S_BLEND,
        S_RESULT
    } t_state;

    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v,
                                                       input logic [TILE_W-1:0] tm1);
        return ({1'b0, v} > tm1) ? tm1[COORD_W-1:0] : v;
    endfunction

    function automatic logic [COORD_W-1:0] wrap_dist(input logic [COORD_W-1:0] a,
                                                     input logic [COORD_W-1:0] b,
                                                     input logic [TILE_W-1:0] t);
        logic [COORD_W-1:0] d;
        logic [TILE_W-1:0]  e;
        d = (a > b) ? (a - b) : (b - a);
        e = t - {1'b0, d};
        return ({1'b0, d} < e) ? d : e[COORD_W-1:0];
    endfunction

    function automatic logic [COLOR_W-1:0] blend_chan(input logic [COLOR_W-1:0] stone,
                                                      input logic [COLOR_W-1:0] gap,
                                                      input logic [W_W-1:0] w);
        logic [17:0] acc;
        acc = 18'(stone) * 18'(9'd256 - {1'b0, w}) + 18'(gap) * 18'(w) + 18'd128;
        return acc[15:8];
    endfunction

endpackage

// ----- rtl/wvs_chan_if.sv -----
// Valid/ready channel carrying one payload per transaction.
// The payload type is set where the interface is instantiated; no dependencies.
interface wvs_chan_if #(parameter type t_payload = logic) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/wrapped_voronoi_stone_shader.sv -----
// Voronoi stone shader on a wrapping tile: seed table in RAM, nearest-seed scan, blend.
// Depends on wvs_pkg, wvs_chan_if, wvs_ram, wvs_div and the assertion macro header.
//
// The input channel i_pix carries two kinds of transaction. A seed write stores
// position, colour and radius at seed_index and produces no result. A pixel query
// produces exactly one result on o_pix. The block handles one query at a time: it
// reads one seed per cycle from the single RAM read port over the first seed_count
// entries (at most MAX_SEEDS), keeping the nearest, then re-reads the winner.
// A query whose pixel lies in a stone passes through the scan, the winner fetch, the
// radius squaring, the stone test, the weight divider (one quotient bit per divider
// cycle) and the blend before it loads the output register; a query outside every
// stone skips the divider and blend, and a pixel off the tile or a zero seed count
// goes straight to the result. The next transaction is taken in the cycle after.
// The result sits in an output register, so the next transaction is accepted while
// a stalled receiver has not yet taken the previous result; a second finished
// result waits inside until that register is free.
// Configuration writes on i_cfg_* are taken at any clock edge with i_cfg_we high.
// Reset returns the configuration registers and the state to their defaults and empties the output register;
// the seed table is not cleared and must be written before it is searched.
`include "wrapped_voronoi_stone_shader_defines.svh"
module wrapped_voronoi_stone_shader
    import wvs_pkg::*;
#(
    parameter int MAX_SEEDS  = 64,
    parameter int COORD_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    wvs_chan_if.sink              i_pix,
    wvs_chan_if.source            o_pix
);

    localparam int AW = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
    localparam logic [TILE_W-1:0] TILE_LIM =
        (COORD_BITS >= TILE_W) ? {TILE_W{1'b1}} : TILE_W'(1 << COORD_BITS);
    localparam logic [CNT_W-1:0] SEED_LIM =
        (MAX_SEEDS >= (1 << CNT_W) - 1) ? {CNT_W{1'b1}} : CNT_W'(MAX_SEEDS);

    t_state r_state, n_state;

    logic [TILE_W-1:0]  r_tile;
    logic [CNT_W-1:0]   r_count;
    logic [COLOR_W-1:0] r_gap_r, r_gap_g, r_gap_b;

    logic [COORD_W-1:0] r_px, r_py;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_rd_idx;
    logic               r_rd_valid;
    logic               r_found;
    logic [D2_W-1:0]    r_best;
    logic [CNT_W-1:0]   r_win;
    logic [R2_W-1:0]    r_r2;
    t_seed              r_stone;
    t_out_item          r_res;
    t_out_item          r_out;
    logic               r_out_valid;

    logic [TILE_W-1:0]  tile_eff, tile_m1;
    logic [CNT_W-1:0]   n_eff;
    logic               in_ready, in_accept, pix_oor, idx_ok;
    logic               scan_issue, mem_re, mem_we, div_start, out_load, in_stone;
    logic [AW-1:0]      mem_raddr, scan_addr, win_addr, wr_addr;
    logic [AW+CNT_W-1:0] scan_ext, win_ext;
    logic [AW+IDX_W-1:0] wr_ext;
    logic [SEED_W-1:0]  mem_rdata;
    t_seed              rd, wr_seed;
    logic [COORD_W-1:0] sx, sy, dx, dy;
    logic [D2_W-1:0]    d2;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile  <= TILE_RESET;
            r_count <= '0;
            r_gap_r <= '0;
            r_gap_g <= '0;
            r_gap_b <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TILE_SIZE:  r_tile  <= i_cfg_data;
                CFG_SEED_COUNT: r_count <= i_cfg_data[CNT_W-1:0];
                CFG_GAP_RED:    r_gap_r <= i_cfg_data[COLOR_W-1:0];
                CFG_GAP_GREEN:  r_gap_g <= i_cfg_data[COLOR_W-1:0];
                CFG_GAP_BLUE:   r_gap_b <= i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    assign tile_eff = (r_tile == '0) ? TILE_W'(1) : ((r_tile > TILE_LIM) ? TILE_LIM : r_tile);
    assign tile_m1  = tile_eff - 1'b1;
    assign n_eff    = (r_count > SEED_LIM) ? SEED_LIM : r_count;

    assign in_accept = i_pix.valid && in_ready;
    assign pix_oor   = ({1'b0, i_pix.data.pixel_x} >= tile_eff) ||
                       ({1'b0, i_pix.data.pixel_y} >= tile_eff);
    assign idx_ok    = (32'(i_pix.data.seed_index) < MAX_SEEDS);

    assign wr_ext    = {{AW{1'b0}}, i_pix.data.seed_index};
    assign wr_addr   = wr_ext[AW-1:0];
    assign scan_ext  = {{AW{1'b0}}, r_cnt};
    assign scan_addr = scan_ext[AW-1:0];
    assign win_ext   = {{AW{1'b0}}, r_win};
    assign win_addr  = win_ext[AW-1:0];

    assign wr_seed.x      = clamp_coord(i_pix.data.seed_x, tile_m1);
    assign wr_seed.y      = clamp_coord(i_pix.data.seed_y, tile_m1);
    assign wr_seed.red    = i_pix.data.seed_red;
    assign wr_seed.green  = i_pix.data.seed_green;
    assign wr_seed.blue   = i_pix.data.seed_blue;
    assign wr_seed.radius = i_pix.data.seed_radius;
    assign mem_we = in_accept && (i_pix.data.kind == KIND_SEED) && idx_ok;

    wvs_ram #(
        .WIDTH(SEED_W),
        .DEPTH(MAX_SEEDS)
    ) u_seed_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(wr_addr),
        .i_wdata(wr_seed),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign rd = t_seed'(mem_rdata);
    assign sx = clamp_coord(rd.x, tile_m1);
    assign sy = clamp_coord(rd.y, tile_m1);
    assign dx = wrap_dist(r_px, sx, tile_eff);
    assign dy = wrap_dist(r_py, sy, tile_eff);
    assign d2 = D2_W'(16'(dx) * 16'(dx)) + D2_W'(16'(dy) * 16'(dy));

    assign scan_issue = (r_state == S_SCAN) && (r_cnt < n_eff);
    assign in_stone   = (r_r2 != '0) && ({r_best, 8'h00} < {1'b0, r_r2});

    assign div_req.start = div_start;
    assign div_req.num   = {r_best, 18'b0};
    assign div_req.den   = DEN_W'({r_r2, 2'b00}) + DEN_W'(r_r2);

    wvs_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    always_comb begin
        n_state   = r_state;
        in_ready  = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = scan_addr;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_pix.valid && (i_pix.data.kind == KIND_QUERY)) begin
                    n_state = (pix_oor || (n_eff == '0)) ? S_RESULT : S_SCAN;
                end
            end
            S_SCAN: begin
                mem_re = scan_issue;
                if (!scan_issue && !r_rd_valid) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                mem_re    = 1'b1;
                mem_raddr = win_addr;
                n_state   = S_SQUARE;
            end
            S_SQUARE: n_state = S_TEST;
            S_TEST: begin
                if (in_stone) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_BLEND;
                end
            end
            S_BLEND: n_state = S_RESULT;
            S_RESULT: begin
                if (!r_out_valid || o_pix.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= scan_issue;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && (i_pix.data.kind == KIND_QUERY)) begin
            r_px    <= i_pix.data.pixel_x;
            r_py    <= i_pix.data.pixel_y;
            r_cnt   <= '0;
            r_found <= 1'b0;
            r_win   <= '0;
            r_res.out_red      <= r_gap_r;
            r_res.out_green    <= r_gap_g;
            r_res.out_blue     <= r_gap_b;
            r_res.inside_stone <= 1'b0;
            r_res.winner_index <= '0;
            r_res.out_of_range <= pix_oor;
        end
        if (scan_issue) begin
            r_cnt    <= r_cnt + 1'b1;
            r_rd_idx <= r_cnt;
        end
        if (r_rd_valid && (!r_found || (d2 < r_best))) begin
            r_found <= 1'b1;
            r_best  <= d2;
            r_win   <= r_rd_idx;
        end
        if (r_state == S_SQUARE) begin
            r_r2    <= R2_W'(rd.radius) * R2_W'(rd.radius);
            r_stone <= rd;
        end
        if (r_state == S_TEST) begin
            r_res.winner_index <= r_win[IDX_W-1:0];
        end
        if (r_state == S_BLEND) begin
            r_res.out_red      <= blend_chan(r_stone.red, r_gap_r, div_rsp.quot);
            r_res.out_green    <= blend_chan(r_stone.green, r_gap_g, div_rsp.quot);
            r_res.out_blue     <= blend_chan(r_stone.blue, r_gap_b, div_rsp.quot);
            r_res.inside_stone <= 1'b1;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign i_pix.ready = in_ready;
    assign o_pix.valid = r_out_valid;
    assign o_pix.data  = r_out;

    `WVS_ASSERT(a_read_only_in_scan, i_clk, i_rst_n, !r_rd_valid || (r_state == S_SCAN))
    `WVS_ASSERT(a_div_done_in_div, i_clk, i_rst_n, !div_rsp.done || (r_state == S_DIV))
    `WVS_ASSERT(a_weight_bound, i_clk, i_rst_n, (r_state != S_BLEND) || (div_rsp.quot <= MAX_WEIGHT))
    `WVS_ASSERT_NEXT(a_load_shows_result, i_clk, i_rst_n, out_load, o_pix.valid)

endmodule

// ----- rtl/wvs_ram.sv -----
// Generic single-clock RAM, one write port and one read port with registered read data.
// No dependencies.
module wvs_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/wvs_div.sv -----
// Restoring divider for the blend weight, one quotient bit per cycle.
// Depends on wvs_pkg for the request and response structs.
module wvs_div
    import wvs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [NUM_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_den;
    logic [W_W-1:0]    r_q;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic              ge;

    assign ge = (r_rem >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_step == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_step == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.num;
            r_den  <= NUM_W'({i_req.den, {(W_W-1){1'b0}}});
            r_q    <= '0;
            r_step <= STEP_W'(W_W - 1);
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_den;
            end
            r_q    <= {r_q[W_W-2:0], ge};
            r_den  <= r_den >> 1;
            r_step <= r_step - 1'b1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

// ----- tb/wvs_shade_checker.sv -----
// Checker for the stone shader: snoops the configuration port and both channels,
// predicts the shaded colour and flags of every pixel query and compares them with each result.
// Depends on wvs_pkg for the item and seed types and the register constants.
module wvs_shade_checker
    import wvs_pkg::*;
#(
    parameter int MAX_SEEDS  = 64,
    parameter int COORD_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             i_out_data,
    output int                    o_fail_count,
    output int                    o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    t_seed              stones [MAX_SEEDS];
    logic [TILE_W-1:0]  tile_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [COLOR_W-1:0] gap_r;
    logic [COLOR_W-1:0] gap_g;
    logic [COLOR_W-1:0] gap_b;
    t_out_item          shade_q [$];
    t_out_item          want;
    int                 fail_count = 0;
    int                 result_no = 0;

    assign o_fail_count = fail_count;

    function automatic int unsigned tile_span();
        if (tile_reg == '0) return 1;
        if (32'(tile_reg) > (1 << COORD_BITS)) return 1 << COORD_BITS;
        return 32'(tile_reg);
    endfunction

    function automatic int unsigned clamp_to_tile(input int unsigned v, input int unsigned t);
        return (v > t - 1) ? t - 1 : v;
    endfunction

    function automatic int unsigned torus_gap(input int unsigned a, input int unsigned b,
                                              input int unsigned t);
        int unsigned d;
        d = (a > b) ? a - b : b - a;
        return (d < t - d) ? d : t - d;
    endfunction

    function automatic logic [COLOR_W-1:0] mix_channel(input int unsigned stone,
                                                       input int unsigned gap,
                                                       input int unsigned w);
        int unsigned acc;
        acc = (stone * (256 - w) + gap * w + 128) >> 8;
        return acc[COLOR_W-1:0];
    endfunction

    function automatic t_out_item shade_pixel(input t_in_item item);
        t_out_item       res;
        t_seed           s;
        int unsigned     t, n, i, px, py, dx, dy, d2, best, win;
        bit              found;
        longint unsigned r2, w;
        t = tile_span();
        n = (32'(count_reg) > MAX_SEEDS) ? MAX_SEEDS : 32'(count_reg);
        px = 32'(item.pixel_x);
        py = 32'(item.pixel_y);
        res = '0;
        res.out_red = gap_r;
        res.out_green = gap_g;
        res.out_blue = gap_b;
        found = 1'b0;
        best = 0;
        win = 0;
        if (px >= t || py >= t) begin
            res.out_of_range = 1'b1;
            return res;
        end
        for (i = 0; i < n; i++) begin
            dx = torus_gap(px, clamp_to_tile(32'(stones[i].x), t), t);
            dy = torus_gap(py, clamp_to_tile(32'(stones[i].y), t), t);
            d2 = dx * dx + dy * dy;
            if (!found || d2 < best) begin
                found = 1'b1;
                best = d2;
                win = i;
            end
        end
        if (!found) return res;
        res.winner_index = win[IDX_W-1:0];
        s = stones[win];
        r2 = 64'(s.radius);
        r2 = r2 * r2;
        if (r2 != 0 && 64'(best) * 256 < r2) begin
            w = 64'(best);
            w = (w * 262144) / (5 * r2);
            if (w > 255) w = 255;
            res.out_red = mix_channel(32'(s.red), 32'(gap_r), 32'(w));
            res.out_green = mix_channel(32'(s.green), 32'(gap_g), 32'(w));
            res.out_blue = mix_channel(32'(s.blue), 32'(gap_b), 32'(w));
            res.inside_stone = 1'b1;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val) begin
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      result_no, name, got, exp_val));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tile_reg = TILE_RESET;
            count_reg = '0;
            gap_r = '0;
            gap_g = '0;
            gap_b = '0;
            shade_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TILE_SIZE:  tile_reg = i_cfg_data[TILE_W-1:0];
                    CFG_SEED_COUNT: count_reg = i_cfg_data[CNT_W-1:0];
                    CFG_GAP_RED:    gap_r = i_cfg_data[COLOR_W-1:0];
                    CFG_GAP_GREEN:  gap_g = i_cfg_data[COLOR_W-1:0];
                    CFG_GAP_BLUE:   gap_b = i_cfg_data[COLOR_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                result_no++;
                if (shade_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no query waiting",
                                              result_no));
                end else begin
                    want = shade_q.pop_front();
                    check_field("out_red", 32'(i_out_data.out_red), 32'(want.out_red));
                    check_field("out_green", 32'(i_out_data.out_green),
                                32'(want.out_green));
                    check_field("out_blue", 32'(i_out_data.out_blue), 32'(want.out_blue));
                    check_field("inside_stone", 32'(i_out_data.inside_stone),
                                32'(want.inside_stone));
                    check_field("winner_index", 32'(i_out_data.winner_index),
                                32'(want.winner_index));
                    check_field("out_of_range", 32'(i_out_data.out_of_range),
                                32'(want.out_of_range));
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.kind == KIND_QUERY) begin
                    shade_q.insert(shade_q.size(), shade_pixel(i_in_data));
                end else if (32'(i_in_data.seed_index) < MAX_SEEDS) begin
                    stones[i_in_data.seed_index].x =
                        COORD_W'(clamp_to_tile(32'(i_in_data.seed_x), tile_span()));
                    stones[i_in_data.seed_index].y =
                        COORD_W'(clamp_to_tile(32'(i_in_data.seed_y), tile_span()));
                    stones[i_in_data.seed_index].red = i_in_data.seed_red;
                    stones[i_in_data.seed_index].green = i_in_data.seed_green;
                    stones[i_in_data.seed_index].blue = i_in_data.seed_blue;
                    stones[i_in_data.seed_index].radius = i_in_data.seed_radius;
                end
            end
        end
        o_outstanding <= shade_q.size();
    end

endmodule

// ----- tb/tb_top.sv -----
// Top of the stone shader testbench: clock, reset, seed and pixel stimulus,
// register programming and the verdict. Depends on wvs_pkg, wvs_chan_if,
// the shader RTL and wvs_shade_checker, which does all prediction and checking.
module tb_top
    import wvs_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 5;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 100;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 80;
    localparam int SEED_SLOTS    = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd5;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    outstanding;
    int                    cycle_count = 0;
    int                    src_idle_pct = 0;
    int                    sink_stall_pct = 0;
    int unsigned           tile_now = 16;

    wvs_chan_if #(.t_payload(t_in_item))  pix_in ();
    wvs_chan_if #(.t_payload(t_out_item)) pix_out ();

    wrapped_voronoi_stone_shader i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_in),
        .o_pix      (pix_out)
    );

    wvs_shade_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (pix_in.valid),
        .i_in_ready    (pix_in.ready),
        .i_in_data     (pix_in.data),
        .i_out_valid   (pix_out.valid),
        .i_out_ready   (pix_out.ready),
        .i_out_data    (pix_out.data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk) begin
        pix_out.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    function automatic t_in_item noise_item();
        logic [95:0] bits;
        bits = {$urandom, $urandom, $urandom};
        return bits[$bits(t_in_item)-1:0];
    endfunction

    function automatic logic [7:0] rand_level();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] rand_coord();
        if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, tile_now - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_in_item seed_item(input int unsigned idx, input int unsigned x,
                                           input int unsigned y, input int unsigned red,
                                           input int unsigned green, input int unsigned blue,
                                           input int unsigned radius);
        t_in_item item;
        item = noise_item();
        item.kind = KIND_SEED;
        item.seed_index = IDX_W'(idx);
        item.seed_x = COORD_W'(x);
        item.seed_y = COORD_W'(y);
        item.seed_red = COLOR_W'(red);
        item.seed_green = COLOR_W'(green);
        item.seed_blue = COLOR_W'(blue);
        item.seed_radius = RAD_W'(radius);
        return item;
    endfunction

    function automatic t_in_item query_item(input int unsigned x, input int unsigned y);
        t_in_item item;
        item = noise_item();
        item.kind = KIND_QUERY;
        item.pixel_x = COORD_W'(x);
        item.pixel_y = COORD_W'(y);
        return item;
    endfunction

    function automatic t_in_item random_seed(input int unsigned idx);
        int unsigned radius;
        case ($urandom_range(0, 7))
            0: radius = 0;
            1: radius = 4095;
            2, 3: radius = $urandom_range(0, 4095);
            default: radius = $urandom_range(0, 4 * tile_now);
        endcase
        return seed_item(idx, 32'(rand_coord()), 32'(rand_coord()), 32'(rand_level()),
                         32'(rand_level()), 32'(rand_level()), radius);
    endfunction

    function automatic int unsigned pick_tile();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 1;
            2: return 256;
            3: return $urandom_range(257, 511);
            4: return 2;
            5, 6: return $urandom_range(65, 255);
            default: return $urandom_range(3, 64);
        endcase
    endfunction

    task automatic send_item(input t_in_item item);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            pix_in.valid <= 1'b0;
            @(posedge clk);
        end
        pix_in.valid <= 1'b1;
        pix_in.data <= item;
        do @(posedge clk); while (!pix_in.ready);
    endtask

    task automatic settle();
        pix_in.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge clk);
    endtask

    task automatic program_shader(input int unsigned tile, input int unsigned cnt,
                                  input int unsigned red, input int unsigned green,
                                  input int unsigned blue);
        cfg_put(CFG_TILE_SIZE, tile);
        cfg_put(CFG_SEED_COUNT, cnt);
        cfg_put(CFG_GAP_RED, red);
        cfg_put(CFG_GAP_GREEN, green);
        cfg_put(CFG_GAP_BLUE, blue);
        cfg_put(CFG_SPARE + CFG_IDX_W'($urandom_range(0, 2)), $urandom);
        cfg_we <= 1'b0;
        tile_now = (tile == 0) ? 1 : ((tile > 256) ? 256 : tile);
    endtask

    initial begin
        int unsigned tile, cnt;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_idx <= '0;
        cfg_data <= '0;
        pix_in.valid <= 1'b0;
        pix_in.data <= '0;
        src_idle_pct = 35;
        sink_stall_pct = 83;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(query_item(5, 5));
        send_item(query_item(16, 3));
        send_item(query_item(3, 255));
        send_item(seed_item(0, 2, 2, 255, 255, 255, 32));
        send_item(seed_item(1, 255, 255, 0, 0, 0, 0));
        send_item(seed_item(2, 10, 2, 170, 85, 15, 48));
        send_item(seed_item(3, 6, 2, 1, 2, 4, 4095));
        send_item(seed_item(63, 128, 64, 255, 0, 255, 2730));
        settle();
        program_shader(16, 4, 200, 100, 50);
        send_item(query_item(2, 2));
        send_item(query_item(4, 2));
        send_item(query_item(15, 15));
        send_item(query_item(0, 15));
        send_item(query_item(11, 2));
        send_item(query_item(13, 2));
        settle();
        program_shader(8, 4, 0, 255, 0);
        send_item(query_item(7, 7));
        send_item(query_item(6, 2));
        send_item(query_item(8, 0));
        settle();
        program_shader(0, 4, 255, 255, 255);
        send_item(query_item(0, 0));
        send_item(query_item(1, 0));
        settle();
        program_shader(511, 4, 0, 0, 0);
        send_item(query_item(255, 255));

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase < PHASES / 3) begin
                src_idle_pct = 35;
                sink_stall_pct = 83;
            end else if (phase < 2 * PHASES / 3) begin
                src_idle_pct = 83;
                sink_stall_pct = 35;
            end else begin
                src_idle_pct = 0;
                sink_stall_pct = 0;
            end
            case (phase)
                0: begin tile = 256; cnt = 64; end
                1: begin tile = 0; cnt = 127; end
                2: begin tile = 511; cnt = 1; end
                3: begin tile = 2; cnt = 0; end
                4: begin tile = 1; cnt = 64; end
                default: begin
                    tile = pick_tile();
                    case ($urandom_range(0, 5))
                        0: cnt = 0;
                        1: cnt = $urandom_range(65, 127);
                        default: cnt = $urandom_range(1, 64);
                    endcase
                end
            endcase
            settle();
            program_shader(tile, cnt, 32'(rand_level()), 32'(rand_level()),
                           32'(rand_level()));
            // The whole table is filled before any query may search past the directed seeds.
            if (phase == 0) begin
                for (int idx = 0; idx < SEED_SLOTS; idx++) send_item(random_seed(idx));
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 99) < 70) begin
                    send_item(query_item(32'(rand_coord()), 32'(rand_coord())));
                end else begin
                    send_item(random_seed($urandom_range(0, SEED_SLOTS - 1)));
                end
            end
        end

        settle();
        if (fail_count == 0 && outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
